// File: design/source_text_tokenizer_macros.svh
// assertion macros shared by the tokenizer rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// checked outside reset only
`define STTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define STTK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/sttk_pkg.sv
// types, constants and helper functions of the source text tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sttk_pkg;

  localparam int CNT_W      = 16;   // line, column and length counters
  localparam int FIELD_W    = 16;   // width of the position and length fields
  localparam int KIND_W     = 5;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int MAX_TOKENS = 3;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [KIND_W-1:0]  kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SPACE = 2'd1,
    MODE_IDENT = 2'd2,
    MODE_EOL   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_CR   = 2'd1,
    HELD_LF   = 2'd2
  } held_e;

  localparam kind_t KIND_UNKNOWN = 5'd0;
  localparam kind_t KIND_IDENT   = 5'd1;
  localparam kind_t KIND_SPACE   = 5'd4;
  localparam kind_t KIND_EOL     = 5'd5;
  localparam kind_t KIND_LT      = 5'd6;
  localparam kind_t KIND_EQ      = 5'd7;
  localparam kind_t KIND_COMMA   = 5'd8;
  localparam kind_t KIND_SEMI    = 5'd9;
  localparam kind_t KIND_GT      = 5'd10;
  localparam kind_t KIND_STAR    = 5'd11;
  localparam kind_t KIND_HASH    = 5'd12;
  localparam kind_t KIND_LPAREN  = 5'd13;
  localparam kind_t KIND_RPAREN  = 5'd14;
  localparam kind_t KIND_LBRACE  = 5'd15;
  localparam kind_t KIND_RBRACE  = 5'd16;
  localparam kind_t KIND_LBRACK  = 5'd17;
  localparam kind_t KIND_RBRACK  = 5'd18;
  localparam kind_t KIND_EOF     = 5'd19;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef struct packed {
    kind_t  kind;
    field_t line;
    field_t column;
    field_t length;
    logic   last;
  } token_t;

  // tokens caused by one byte, lowest index first
  typedef struct packed {
    logic [1:0]                 count;
    token_t [MAX_TOKENS-1:0]    tok;
  } lex_out_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == {CNT_W{1'b1}}) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

  // low field bits of a counter, zero extended when the counter is narrower
  function automatic field_t to_field(cnt_t v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[FIELD_W-1:0];
  endfunction

  function automatic token_t mk_tok(kind_t kind, cnt_t line, cnt_t col, cnt_t len);
    token_t t;
    t.kind   = kind;
    t.line   = to_field(line);
    t.column = to_field(col);
    t.length = to_field(len);
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_break(logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic kind_t punct_kind(logic [7:0] b);
    kind_t k;
    case (b)
      8'h3C:   k = KIND_LT;
      8'h3D:   k = KIND_EQ;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMI;
      8'h3E:   k = KIND_GT;
      8'h2A:   k = KIND_STAR;
      CH_HASH: k = KIND_HASH;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h5B:   k = KIND_LBRACK;
      8'h5D:   k = KIND_RBRACK;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: design/sttk_if.sv
// valid/ready channel interfaces for source bytes and tokens
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sttk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface sttk_token_if;
  logic         valid;
  logic         ready;
  logic [4:0]   token_kind;
  logic [15:0]  start_line;
  logic [15:0]  start_column;
  logic [15:0]  token_length;
  logic         last_of_run;

  modport source (output valid, output token_kind, output start_line,
                  output start_column, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input start_line,
                  input start_column, input token_length, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: design/sttk_lexer.sv
// lexer state and single-pass token decision for one source byte
// depends on sttk_pkg and source_text_tokenizer_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "source_text_tokenizer_macros.svh"

module sttk_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         char_byte_i,
  output sttk_pkg::lex_out_t lex_o
);
  import sttk_pkg::*;

  mode_e mode_q, mode_d;
  held_e held_q, held_d;
  cnt_t  line_q, line_d;
  cnt_t  col_q, col_d;
  cnt_t  osl_q, osl_d;
  cnt_t  osc_q, osc_d;
  cnt_t  olen_q, olen_d;

  always_comb begin
    logic [1:0]              n;
    token_t [MAX_TOKENS-1:0] toks;
    logic                    fresh;
    logic                    hb_cr;
    kind_t                   pk;
    logic [7:0]              b;

    b      = char_byte_i;
    mode_d = mode_q;
    held_d = held_q;
    line_d = line_q;
    col_d  = col_q;
    osl_d  = osl_q;
    osc_d  = osc_q;
    olen_d = olen_q;
    n      = 2'd0;
    toks   = '0;
    fresh  = 1'b1;
    hb_cr  = 1'b0;

    // close or extend the open run
    if (mode_q == MODE_SPACE) begin
      if (is_blank(b)) begin
        col_d = sat_inc(col_q);
        fresh = 1'b0;
      end else begin
        toks[n] = mk_tok(KIND_SPACE, osl_q, osc_q, '0);
        n       = n + 2'd1;
        mode_d  = MODE_IDLE;
      end
    end else if (mode_q == MODE_IDENT) begin
      if (is_letter(b) || is_digit(b) || b == CH_DASH || b == CH_UNDER) begin
        olen_d = sat_inc(olen_q);
        col_d  = sat_inc(col_q);
        fresh  = 1'b0;
      end else begin
        toks[n] = mk_tok(KIND_IDENT, osl_q, osc_q, olen_q);
        n       = n + 2'd1;
        mode_d  = MODE_IDLE;
      end
    end else if (held_q != HELD_NONE) begin
      hb_cr  = (held_q == HELD_CR);
      held_d = HELD_NONE;
      if (is_break(b) && ((b == CH_CR) != hb_cr)) begin
        line_d = sat_inc(line_q);
        col_d  = cnt_t'(1);
        mode_d = MODE_EOL;
        fresh  = 1'b0;
      end else begin
        if (mode_q == MODE_EOL) begin
          toks[n] = mk_tok(KIND_EOL, osl_q, osc_q, '0);
          n       = n + 2'd1;
        end
        mode_d  = MODE_IDLE;
        // lone break reported at its own place
        toks[n] = mk_tok(KIND_UNKNOWN, line_q, col_q, '0);
        n       = n + 2'd1;
        col_d   = sat_inc(col_q);
      end
    end else if (mode_q == MODE_EOL) begin
      if (is_break(b)) begin
        held_d = (b == CH_CR) ? HELD_CR : HELD_LF;
        fresh  = 1'b0;
      end else begin
        toks[n] = mk_tok(KIND_EOL, osl_q, osc_q, '0);
        n       = n + 2'd1;
        mode_d  = MODE_IDLE;
      end
    end

    // lex the byte afresh
    pk = punct_kind(b);
    if (fresh) begin
      if (b == CH_NUL) begin
        toks[n] = mk_tok(KIND_EOF, line_d, col_d, '0);
        n       = n + 2'd1;
        mode_d  = MODE_IDLE;
        held_d  = HELD_NONE;
        line_d  = cnt_t'(1);
        col_d   = cnt_t'(1);
        osl_d   = '0;
        osc_d   = '0;
        olen_d  = '0;
      end else if (pk != KIND_UNKNOWN) begin
        toks[n] = mk_tok(pk, line_d, col_d, cnt_t'(1));
        n       = n + 2'd1;
        col_d   = sat_inc(col_d);
      end else if (is_blank(b)) begin
        mode_d = MODE_SPACE;
        osl_d  = line_d;
        osc_d  = col_d;
        olen_d = '0;
        col_d  = sat_inc(col_d);
      end else if (is_break(b)) begin
        held_d = (b == CH_CR) ? HELD_CR : HELD_LF;
        osl_d  = line_d;
        osc_d  = col_d;
        olen_d = '0;
      end else if (is_letter(b)) begin
        mode_d = MODE_IDENT;
        osl_d  = line_d;
        osc_d  = col_d;
        olen_d = cnt_t'(1);
        col_d  = sat_inc(col_d);
      end else begin
        toks[n] = mk_tok(KIND_UNKNOWN, line_d, col_d, '0);
        n       = n + 2'd1;
        col_d   = sat_inc(col_d);
      end
    end

    if (n != 2'd0) begin
      toks[n - 2'd1].last = 1'b1;
    end

    lex_o.count = n;
    lex_o.tok   = toks;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      held_q <= HELD_NONE;
      line_q <= cnt_t'(1);
      col_q  <= cnt_t'(1);
      osl_q  <= '0;
      osc_q  <= '0;
      olen_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
      line_q <= line_d;
      col_q  <= col_d;
      osl_q  <= osl_d;
      osc_q  <= osc_d;
      olen_q <= olen_d;
    end
  end

  `STTK_ASSERT(a_eof_restarts, step_i && char_byte_i == CH_NUL |=> mode_q == MODE_IDLE && held_q == HELD_NONE && line_q == cnt_t'(1) && col_q == cnt_t'(1), "end of input did not restart the counters")
  `STTK_ASSERT(a_held_mode, held_q != HELD_NONE |-> mode_q == MODE_IDLE || mode_q == MODE_EOL, "line break held inside a space or identifier run")
  `STTK_ASSERT(a_ident_len, mode_q == MODE_IDENT |-> olen_q != '0, "open identifier has zero length")

endmodule

`default_nettype wire

// File: design/source_text_tokenizer.sv
// top level of the source text tokenizer: lexer plus token queue
// depends on sttk_pkg, sttk_if, sttk_lexer and source_text_tokenizer_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "source_text_tokenizer_macros.svh"

// Source text tokenizer. Takes one source byte per beat on char_i and
// delivers tokens (kind, start line, start column, length, last_of_run) on
// token_o. A byte is lexed in the cycle it is accepted, against the lexer
// state, and the zero to three tokens it completes enter a four-entry token
// queue at once; last_of_run marks the final token of each byte. Bytes are
// taken at one per cycle as long as each completes at most one token and the
// consumer takes a token each cycle: the single token port, one token per
// beat, sets that figure, so a byte that closes two or three tokens (a run
// cut short by punctuation, a lone line break, end of input inside a run)
// holds char_i.ready low while the queue drains. A CR or LF is held back for
// one byte of lookahead, and a zero byte emits EOF and restarts line and
// column at 1. There is no clearing pass after reset.
module source_text_tokenizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  sttk_byte_if.sink     char_i,
  sttk_token_if.source  token_o
);
  import sttk_pkg::*;

  lex_out_t lex;
  logic     in_acc;
  logic     pop;
  logic [1:0] push_n;

  // token queue, payload kept without reset
  token_t                fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW:0]      cnt_q, cnt_d;
  token_t                head;

  // room for the worst case of three tokens from the next byte
  assign char_i.ready = (cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH - MAX_TOKENS));
  assign in_acc       = char_i.valid && char_i.ready;

  sttk_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .char_byte_i (char_i.char_byte),
    .lex_o       (lex)
  );

  assign push_n = in_acc ? lex.count : 2'd0;

  // head of queue drives the output beat
  assign head                 = fifo_q[rd_ptr_q];
  assign token_o.valid        = (cnt_q != '0);
  assign token_o.token_kind   = head.kind;
  assign token_o.start_line   = head.line;
  assign token_o.start_column = head.column;
  assign token_o.token_length = head.length;
  assign token_o.last_of_run  = head.last;
  assign pop                  = token_o.valid && token_o.ready;

  always_comb begin
    rd_ptr_d = pop ? rd_ptr_q + (FIFO_AW)'(1) : rd_ptr_q;
    wr_ptr_d = wr_ptr_q + (FIFO_AW)'(push_n);
    cnt_d    = cnt_q + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
  end

  // tokens of one byte land in consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (2'(i) < push_n) begin
        fifo_q[wr_ptr_q + (FIFO_AW)'(i)] <= lex.tok[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `STTK_ASSERT(a_no_overflow, in_acc |-> cnt_q + (FIFO_AW + 1)'(lex.count) <= (FIFO_AW + 1)'(FIFO_DEPTH), "token queue overflow")
  `STTK_ASSERT(a_push_visible, in_acc && lex.count != 2'd0 |=> token_o.valid, "tokens of an accepted byte not offered")
  `STTK_ASSERT(a_ptr_gap, cnt_q == '0 |-> rd_ptr_q == wr_ptr_q, "empty queue with pointers apart")

endmodule

`default_nettype wire
